// File: rtl/mld_listener_group_table_unit_defines.svh
// Assertion macros for the multicast listener table checker.
// Needs clk and rst in the scope of the use.
`ifndef MLD_LISTENER_GROUP_TABLE_UNIT_DEFINES_SVH
`define MLD_LISTENER_GROUP_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define MLGT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mlgt check failed");

// next-cycle implication, off during reset
`define MLGT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mlgt check failed");

// next-cycle implication that also holds across reset
`define MLGT_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mlgt check failed");

`endif

// File: rtl/mlgt_pkg.sv
// Shared types, codes and helper functions of the multicast listener table.
// No dependencies.
package mlgt_pkg;

  localparam int ENTRIES  = 16;
  localparam int IF_COUNT = 4;
  localparam int RETRIES  = 8;
  localparam int IDX_W    = $clog2(ENTRIES + 1);
  localparam int RTY_W    = $clog2(RETRIES + 1);
  localparam int CFG_IDX_W = 1;

  // operation codes
  localparam logic [2:0] FN_JOIN   = 3'd0;
  localparam logic [2:0] FN_LEAVE  = 3'd1;
  localparam logic [2:0] FN_FIND   = 3'd2;
  localparam logic [2:0] FN_QUERY  = 3'd3;
  localparam logic [2:0] FN_REPORT = 3'd4;
  localparam logic [2:0] FN_TICK   = 3'd5;
  localparam logic [2:0] FN_CLEAR  = 3'd6;
  localparam logic [2:0] FN_UNDEF  = 3'd7;

  // status codes
  localparam logic [1:0] RS_OK   = 2'd0;
  localparam logic [1:0] RS_ERR  = 2'd1;
  localparam logic [1:0] RS_BUSY = 2'd2;

  // listener states
  localparam logic [1:0] LS_NON   = 2'd0;
  localparam logic [1:0] LS_DELAY = 2'd1;
  localparam logic [1:0] LS_IDLE  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_URI  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DONE = 1'b1;

  localparam logic [31:0] URI_RESET    = 32'd10000;
  localparam logic [31:0] XS_ZERO_SEED = 32'h9E3779B9;
  localparam logic [IDX_W-1:0] IDX_NONE = IDX_W'(ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  typedef struct packed {
    logic        used;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  nif;
    logic [1:0]  st;
    logic        flag;
    logic [31:0] dl;
  } entry_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] index;
    logic [63:0]      ghigh;
    logic [63:0]      glow;
    logic [31:0]      dl;
    logic [1:0]       st;
    logic [7:0]       nif;
    logic             last;
    logic             report_now;
    logic             done_now;
    logic [IDX_W-1:0] expired;
  } res_t;

  typedef struct packed {
    logic        load;
    logic [31:0] seed;
    logic        start;
    logic [31:0] bound;
  } drw_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } drw_rsp_t;

  // scope above interface-local and not the all-nodes group
  function automatic logic reportable(input logic [63:0] hi, input logic [63:0] lo);
    return (hi[51:48] > 4'd1) && !(hi == 64'hFF02000000000000 && lo == 64'd1);
  endfunction

  function automatic logic is_due(input logic [31:0] now, input logic [31:0] dl);
    logic [31:0] diff;
    diff = now - dl;
    return !diff[31];
  endfunction

  function automatic logic [31:0] remaining(input logic [31:0] now, input logic [31:0] dl);
    return is_due(now, dl) ? 32'd0 : (dl - now);
  endfunction

  function automatic logic [31:0] xs32(input logic [31:0] x);
    logic [31:0] v;
    v = (x == 32'd0) ? XS_ZERO_SEED : x;
    v = v ^ (v << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    return v;
  endfunction

  function automatic logic [31:0] smear(input logic [31:0] b);
    logic [31:0] m;
    m = b;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    return m;
  endfunction

  function automatic res_t show(input res_t r, input entry_t e, input logic [IDX_W-1:0] idx);
    res_t o;
    o       = r;
    o.index = idx;
    o.ghigh = e.hi;
    o.glow  = e.lo;
    o.dl    = e.dl;
    o.st    = e.st;
    o.nif   = e.nif;
    o.last  = e.flag;
    return o;
  endfunction

endpackage

// File: rtl/mlgt_if.sv
// Valid/ready channels of the multicast listener table: request, response, config.
// Depends on mlgt_pkg.
interface mlgt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [63:0] group_high;
  logic [63:0] group_low;
  logic [7:0]  netif;
  logic [31:0] now_ms;
  logic [31:0] random_word;
  logic [31:0] resp_limit_ms;
  logic        general_query;
  modport source(output valid, func, group_high, group_low, netif, now_ms, random_word,
                 resp_limit_ms, general_query, input ready);
  modport sink(input valid, func, group_high, group_low, netif, now_ms, random_word,
               resp_limit_ms, general_query, output ready);
endinterface

interface mlgt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [mlgt_pkg::IDX_W-1:0]   entry_index;
  logic [63:0]                  out_group_high;
  logic [63:0]                  out_group_low;
  logic [31:0]                  out_deadline_ms;
  logic [1:0]                   out_state;
  logic [7:0]                   out_netif;
  logic                         out_last_reporter;
  logic                         report_now;
  logic                         done_now;
  logic [mlgt_pkg::IDX_W-1:0]   expired_count;
  modport source(output valid, status, entry_index, out_group_high, out_group_low,
                 out_deadline_ms, out_state, out_netif, out_last_reporter, report_now,
                 done_now, expired_count, input ready);
  modport sink(input valid, status, entry_index, out_group_high, out_group_low,
               out_deadline_ms, out_state, out_netif, out_last_reporter, report_now,
               done_now, expired_count, output ready);
endinterface

interface mlgt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mlgt_pkg::CFG_IDX_W-1:0]   index;
  logic [31:0]                      data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/mld_listener_group_table_unit.sv
// Clear, unknown code and early errors go straight to the response register; other
// operations take one scan pass and one update pass over the entry ring, plus one
// random draw per delay; a general query draws once per reportable entry on the
// interface. One operation in flight at a time.
// Reset clears control and the result register; the table is unusable until clear.
// Top level of the multicast listener table. Depends on mlgt_pkg, mlgt_if, mlgt_cell,
// mlgt_draw.
module mld_listener_group_table_unit (
  input  logic     clk,
  input  logic     rst,
  mlgt_req_if.sink   req,
  mlgt_rsp_if.source rsp,
  mlgt_cfg_if.sink   cfg
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_APPLY = 5'b00100,
    S_DRAW  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  localparam int IW = mlgt_pkg::IDX_W;

  state_t           state;
  logic [IW-1:0]    pos;
  logic [2:0]       func_q;
  logic [63:0]      hi_q;
  logic [63:0]      lo_q;
  logic [7:0]       nif_q;
  logic [31:0]      now_q;
  logic [31:0]      maxr_q;
  logic             gen_q;
  logic             table_ready;
  logic [31:0]      uri;
  logic             done_every;
  logic [IW-1:0]    match_idx;
  logic [IW-1:0]    free_idx;
  logic [IW-1:0]    due_idx;
  logic [IW-1:0]    due_cnt;
  logic [IW-1:0]    target;
  logic             join_new;
  mlgt_pkg::res_t   res;
  mlgt_pkg::res_t   out_q;
  logic             out_valid;
  logic             out_load;

  logic             accept;
  logic             clr;
  logic             shift;
  logic             step;
  logic             need_draw;
  mlgt_pkg::entry_t ring [mlgt_pkg::ENTRIES];
  mlgt_pkg::entry_t h;
  mlgt_pkg::entry_t head_new;
  mlgt_pkg::entry_t armed;
  mlgt_pkg::res_t   res_pre;
  mlgt_pkg::res_t   res_step;
  logic             can_run;
  logic             hmatch;
  logic             hdue;
  logic             hrep;
  logic             rep_in;
  logic             at_tgt;
  logic             keep;
  logic             eligible;
  logic [IW-1:0]    match_n;
  logic [IW-1:0]    free_n;
  logic [IW-1:0]    due_idx_n;
  logic [IW-1:0]    due_cnt_n;
  mlgt_pkg::drw_req_t drw_req;
  mlgt_pkg::drw_rsp_t drw_rsp;

  assign accept = req.valid && req.ready;
  assign req.ready = state == S_IDLE;
  assign cfg.ready = 1'b1;
  assign clr = accept && req.func == mlgt_pkg::FN_CLEAR;

  // entry ring: cell 0 is the head, its updated entry re-enters at the tail
  assign h = ring[0];
  for (genvar g = 0; g < mlgt_pkg::ENTRIES; g++) begin : g_cell
    mlgt_pkg::entry_t d_in;
    if (g == mlgt_pkg::ENTRIES - 1) begin : g_tail
      assign d_in = head_new;
    end else begin : g_body
      assign d_in = ring[g+1];
    end
    mlgt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .clr   (clr),
      .d     (d_in),
      .q     (ring[g])
    );
  end

  mlgt_draw u_draw (
    .clk (clk),
    .rst (rst),
    .req (drw_req),
    .rsp (drw_rsp)
  );

  // request checks and error defaults set up front
  always_comb begin
    can_run = table_ready && req.func <= mlgt_pkg::FN_TICK;
    if (req.func == mlgt_pkg::FN_JOIN &&
        (req.netif >= 8'(mlgt_pkg::IF_COUNT) || req.group_high[63:56] != 8'hFF)) begin
      can_run = 1'b0;
    end
    if ((req.func == mlgt_pkg::FN_LEAVE || req.func == mlgt_pkg::FN_QUERY) &&
        req.netif >= 8'(mlgt_pkg::IF_COUNT)) begin
      can_run = 1'b0;
    end
    res_pre = res;
    res_pre.status = mlgt_pkg::RS_ERR;
    unique case (req.func)
      mlgt_pkg::FN_JOIN, mlgt_pkg::FN_QUERY: begin
        res_pre.index = mlgt_pkg::IDX_NONE;
        res_pre.report_now = 1'b0;
      end
      mlgt_pkg::FN_LEAVE: begin
        res_pre.index = mlgt_pkg::IDX_NONE;
        res_pre.done_now = 1'b0;
      end
      mlgt_pkg::FN_FIND: begin
        res_pre.index = mlgt_pkg::IDX_NONE;
        res_pre.ghigh = '0;
        res_pre.glow  = '0;
        res_pre.st    = mlgt_pkg::LS_NON;
        res_pre.dl    = '0;
      end
      mlgt_pkg::FN_REPORT: begin
        res_pre.index = mlgt_pkg::IDX_NONE;
      end
      mlgt_pkg::FN_TICK: begin
        res_pre.index = mlgt_pkg::IDX_NONE;
        res_pre.expired = '0;
        res_pre.report_now = 1'b0;
      end
      mlgt_pkg::FN_CLEAR: begin
        res_pre.status = mlgt_pkg::RS_OK;
      end
      default: begin
      end
    endcase
  end

  // head inspection during the scan pass
  always_comb begin
    hmatch = h.used && h.nif == nif_q && h.hi == hi_q && h.lo == lo_q;
    hdue   = h.used && h.st == mlgt_pkg::LS_DELAY && mlgt_pkg::is_due(now_q, h.dl);
    match_n   = (hmatch && match_idx == mlgt_pkg::IDX_NONE) ? pos : match_idx;
    free_n    = (!h.used && free_idx == mlgt_pkg::IDX_NONE) ? pos : free_idx;
    due_idx_n = (hdue && due_idx == mlgt_pkg::IDX_NONE) ? pos : due_idx;
    due_cnt_n = due_cnt + IW'(hdue);
  end

  // head update during the apply pass
  always_comb begin
    hrep     = mlgt_pkg::reportable(h.hi, h.lo);
    rep_in   = mlgt_pkg::reportable(hi_q, lo_q);
    at_tgt   = pos == target;
    eligible = h.used && h.nif == nif_q && hrep;
    keep     = h.st == mlgt_pkg::LS_DELAY && maxr_q >= mlgt_pkg::remaining(now_q, h.dl);
    armed    = h;
    armed.dl = now_q + drw_rsp.value;
    armed.st = mlgt_pkg::LS_DELAY;
    need_draw = 1'b0;
    unique case (func_q)
      mlgt_pkg::FN_JOIN:  need_draw = join_new && at_tgt && rep_in;
      mlgt_pkg::FN_QUERY: need_draw = gen_q ? eligible : (at_tgt && hrep);
      default:            need_draw = 1'b0;
    endcase
    step  = (state == S_APPLY && !need_draw) || (state == S_DRAW && drw_rsp.done);
    shift = state == S_SCAN || step;

    head_new = h;
    res_step = res;
    unique case (func_q)
      mlgt_pkg::FN_JOIN: begin
        if (at_tgt) begin
          if (join_new) begin
            head_new.used = 1'b1;
            head_new.hi   = hi_q;
            head_new.lo   = lo_q;
            head_new.nif  = nif_q;
            head_new.st   = rep_in ? mlgt_pkg::LS_DELAY : mlgt_pkg::LS_IDLE;
            head_new.flag = rep_in;
            head_new.dl   = rep_in ? (now_q + drw_rsp.value) : 32'd0;
            res_step.report_now = rep_in;
          end
          res_step = mlgt_pkg::show(res_step, head_new, pos);
          res_step.status = mlgt_pkg::RS_OK;
        end
      end
      mlgt_pkg::FN_LEAVE: begin
        if (at_tgt) begin
          res_step.done_now = done_every ? rep_in : h.flag;
          res_step.last   = h.flag;
          head_new        = '0;
          res_step.index  = pos;
          res_step.ghigh  = hi_q;
          res_step.glow   = lo_q;
          res_step.dl     = '0;
          res_step.st     = mlgt_pkg::LS_NON;
          res_step.nif    = nif_q;
          res_step.status = mlgt_pkg::RS_OK;
        end
      end
      mlgt_pkg::FN_FIND: begin
        if (at_tgt) begin
          res_step = mlgt_pkg::show(res_step, h, pos);
          res_step.status = mlgt_pkg::RS_OK;
        end
      end
      mlgt_pkg::FN_QUERY: begin
        if (gen_q) begin
          if (eligible && !keep) begin
            head_new = armed;
            res_step = mlgt_pkg::show(res_step, armed, pos);
          end
        end else if (at_tgt) begin
          if (hrep && !keep) begin
            head_new = armed;
          end
          res_step = mlgt_pkg::show(res_step, head_new, pos);
          res_step.status = mlgt_pkg::RS_OK;
        end
      end
      mlgt_pkg::FN_REPORT: begin
        if (at_tgt) begin
          if (h.st == mlgt_pkg::LS_DELAY) begin
            head_new.st   = mlgt_pkg::LS_IDLE;
            head_new.dl   = '0;
            head_new.flag = 1'b0;
          end
          res_step = mlgt_pkg::show(res_step, head_new, pos);
          res_step.status = mlgt_pkg::RS_OK;
        end
      end
      mlgt_pkg::FN_TICK: begin
        if (at_tgt) begin
          head_new.st   = mlgt_pkg::LS_IDLE;
          head_new.flag = 1'b1;
          head_new.dl   = '0;
          res_step.report_now = 1'b1;
          res_step = mlgt_pkg::show(res_step, head_new, pos);
          res_step.status = mlgt_pkg::RS_OK;
        end
      end
      default: begin
      end
    endcase
    // the scan pass only rotates entries
    if (state == S_SCAN) begin
      head_new = h;
    end
  end

  // draw requests: seed on accept, start on a head that needs a delay
  always_comb begin
    drw_req.load  = accept;
    drw_req.seed  = req.random_word;
    drw_req.start = state == S_APPLY && need_draw;
    drw_req.bound = (func_q == mlgt_pkg::FN_JOIN) ? uri : maxr_q;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      uri        <= mlgt_pkg::URI_RESET;
      done_every <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        mlgt_pkg::CFG_URI:  uri <= cfg.data;
        mlgt_pkg::CFG_DONE: done_every <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  // response register loads when the previous word is gone or leaving
  assign out_load = state == S_OUT && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pos         <= '0;
      table_ready <= 1'b0;
      res         <= '0;
      func_q      <= mlgt_pkg::FN_JOIN;
      gen_q       <= 1'b0;
      target      <= mlgt_pkg::IDX_NONE;
      join_new    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            func_q    <= req.func;
            hi_q      <= req.group_high;
            lo_q      <= req.group_low;
            nif_q     <= req.netif;
            now_q     <= req.now_ms;
            maxr_q    <= req.resp_limit_ms;
            gen_q     <= req.general_query;
            match_idx <= mlgt_pkg::IDX_NONE;
            free_idx  <= mlgt_pkg::IDX_NONE;
            due_idx   <= mlgt_pkg::IDX_NONE;
            due_cnt   <= '0;
            pos       <= '0;
            res       <= res_pre;
            if (req.func == mlgt_pkg::FN_CLEAR) begin
              table_ready <= 1'b1;
            end
            state <= can_run ? S_SCAN : S_OUT;
          end
        end
        S_SCAN: begin
          match_idx <= match_n;
          free_idx  <= free_n;
          due_idx   <= due_idx_n;
          due_cnt   <= due_cnt_n;
          if (pos == mlgt_pkg::IDX_LAST) begin
            pos <= '0;
            unique case (func_q)
              mlgt_pkg::FN_JOIN: begin
                if (match_n != mlgt_pkg::IDX_NONE) begin
                  target   <= match_n;
                  join_new <= 1'b0;
                  state    <= S_APPLY;
                end else if (free_n != mlgt_pkg::IDX_NONE) begin
                  target   <= free_n;
                  join_new <= 1'b1;
                  state    <= S_APPLY;
                end else begin
                  res.status <= mlgt_pkg::RS_BUSY;
                  state      <= S_OUT;
                end
              end
              mlgt_pkg::FN_QUERY: begin
                target <= match_n;
                if (gen_q) begin
                  res.status <= mlgt_pkg::RS_OK;
                  state      <= S_APPLY;
                end else if (match_n != mlgt_pkg::IDX_NONE) begin
                  state <= S_APPLY;
                end else begin
                  state <= S_OUT;
                end
              end
              mlgt_pkg::FN_TICK: begin
                target      <= due_idx_n;
                res.expired <= due_cnt_n;
                if (due_idx_n != mlgt_pkg::IDX_NONE) begin
                  state <= S_APPLY;
                end else begin
                  res.ghigh  <= '0;
                  res.glow   <= '0;
                  res.status <= mlgt_pkg::RS_OK;
                  state      <= S_OUT;
                end
              end
              default: begin
                target <= match_n;
                if (match_n != mlgt_pkg::IDX_NONE) begin
                  state <= S_APPLY;
                end else begin
                  state <= S_OUT;
                end
              end
            endcase
          end else begin
            pos <= pos + 1'b1;
          end
        end
        S_APPLY, S_DRAW: begin
          if (step) begin
            res <= res_step;
            if (pos == mlgt_pkg::IDX_LAST) begin
              pos   <= '0;
              state <= S_OUT;
            end else begin
              pos   <= pos + 1'b1;
              state <= S_APPLY;
            end
          end else if (need_draw && state == S_APPLY) begin
            state <= S_DRAW;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // response word
  assign rsp.valid             = out_valid;
  assign rsp.status            = out_q.status;
  assign rsp.entry_index       = out_q.index;
  assign rsp.out_group_high    = out_q.ghigh;
  assign rsp.out_group_low     = out_q.glow;
  assign rsp.out_deadline_ms   = out_q.dl;
  assign rsp.out_state         = out_q.st;
  assign rsp.out_netif         = out_q.nif;
  assign rsp.out_last_reporter = out_q.last;
  assign rsp.report_now        = out_q.report_now;
  assign rsp.done_now          = out_q.done_now;
  assign rsp.expired_count     = out_q.expired;

endmodule

// File: rtl/mlgt_cell.sv
// One table entry of the rotating chain; takes its neighbor's entry on shift.
// Depends on mlgt_pkg.
module mlgt_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic             clr,
  input  mlgt_pkg::entry_t d,
  output mlgt_pkg::entry_t q
);

  mlgt_pkg::entry_t ent;

  // entry register: clear wins over shift
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      ent <= '0;
    end else if (shift) begin
      ent <= d;
    end
  end

  assign q = ent;

endmodule

// File: rtl/mlgt_draw.sv
// Random delay draw: one xorshift32 step per cycle while busy, masked retries, fallback mask.
// Depends on mlgt_pkg.
module mlgt_draw (
  input  logic               clk,
  input  logic               rst,
  input  mlgt_pkg::drw_req_t req,
  output mlgt_pkg::drw_rsp_t rsp
);

  logic [31:0]                 word;
  logic [31:0]                 bound;
  logic                        busy;
  logic [mlgt_pkg::RTY_W-1:0]  k;
  logic                        done;
  logic [31:0]                 value;
  logic [31:0]                 mask;
  logic [31:0]                 word_next;
  logic [31:0]                 cand;
  logic                        hit;
  logic                        last_try;

  // one candidate per cycle
  always_comb begin
    mask      = mlgt_pkg::smear(bound);
    word_next = mlgt_pkg::xs32(word);
    cand      = word_next & mask;
    hit       = cand <= bound;
    last_try  = k == mlgt_pkg::RTY_W'(mlgt_pkg::RETRIES - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.load) begin
        word <= req.seed;
      end
      if (req.start) begin
        bound <= req.bound;
        k     <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        word <= word_next;
        if (hit || last_try) begin
          busy  <= 1'b0;
          done  <= 1'b1;
          value <= hit ? cand : (word_next & (mask >> 1));
        end else begin
          k <= k + 1'b1;
        end
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.value = value;

endmodule

// File: rtl/mlgt_checker.sv
// Port-level checks of the multicast listener table, bound to the top level.
// Depends on mlgt_pkg and mld_listener_group_table_unit_defines.svh.
`include "mld_listener_group_table_unit_defines.svh"

module mlgt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [1:0]                 rsp_status,
  input logic [mlgt_pkg::IDX_W-1:0] rsp_index
);

  // one word in flight: no accept right after an accept
  `MLGT_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)
  // a stalled response stays offered
  `MLGT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
  // status is ok, error or busy
  `MLGT_ASSERT_NOW(a_status_code, rsp_valid,
    rsp_status == mlgt_pkg::RS_OK || rsp_status == mlgt_pkg::RS_ERR ||
    rsp_status == mlgt_pkg::RS_BUSY)
  // index is an entry or the none marker
  `MLGT_ASSERT_NOW(a_index_range, rsp_valid, rsp_index <= mlgt_pkg::IDX_NONE)
  // reset drops any offered response
  `MLGT_ASSERT_ALWAYS(a_rst_clears, rst, !rsp_valid)

endmodule

bind mld_listener_group_table_unit mlgt_checker u_mlgt_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_index  (rsp.entry_index)
);

// File: tb/sv/mld_listener_group_table_unit_test.sv
// Testbench for the multicast listener group table: directed and random table operations
// checked word by word against an in-bench model of the table, with random idling.
// Depends on mlgt_pkg, mlgt_if and the mld_listener_group_table_unit RTL.
module mld_listener_group_table_unit_test;

  typedef struct {
    logic [2:0]  func;
    logic [63:0] ghi;
    logic [63:0] glo;
    logic [7:0]  nif;
    logic [31:0] now;
    logic [31:0] seed;
    logic [31:0] maxr;
    logic        general;
  } op_word_t;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int POOL_SIZE   = 24;
  localparam int IW          = mlgt_pkg::IDX_W;

  logic clk;
  logic rst;

  mlgt_req_if req ();
  mlgt_rsp_if rsp ();
  mlgt_cfg_if cfg ();

  mld_listener_group_table_unit DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  // model state
  mlgt_pkg::entry_t groups [mlgt_pkg::ENTRIES];
  logic             groups_ready;
  logic [31:0]      uri_bound;
  logic             done_for_all;
  mlgt_pkg::res_t   held_result;

  op_word_t       pending_ops[$];
  mlgt_pkg::res_t expected_results[$];
  int       fail_count;
  int       send_gap;
  int       rsp_stall;
  int       hold_left;
  int       idle_cycles;
  bit       idling_on;
  bit       hold_request;
  logic [31:0] clock_ms;
  logic [63:0] pool_hi [POOL_SIZE];
  logic [63:0] pool_lo [POOL_SIZE];

  // ---------------- table model ----------------
  function automatic logic group_reports(logic [63:0] hi, logic [63:0] lo);
    if (hi[51:48] <= 4'd1) return 1'b0;
    return !(hi == 64'hFF02_0000_0000_0000 && lo == 64'd1);
  endfunction

  function automatic logic deadline_due(logic [31:0] now, logic [31:0] dl);
    logic [31:0] diff;
    diff = now - dl;
    return diff[31] == 1'b0;
  endfunction

  function automatic logic [31:0] mix32(logic [31:0] x);
    logic [31:0] v;
    v = (x == 32'd0) ? 32'h9E37_79B9 : x;
    v = v ^ (v << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    return v;
  endfunction

  // bounded random delay with masked retries
  function automatic logic [31:0] pull_delay(inout logic [31:0] w, input logic [31:0] bound);
    logic [31:0] m;
    logic [31:0] d;
    m = bound;
    m = m | (m >> 1); m = m | (m >> 2); m = m | (m >> 4);
    m = m | (m >> 8); m = m | (m >> 16);
    for (int k = 0; k < mlgt_pkg::RETRIES; k++) begin
      w = mix32(w);
      d = w & m;
      if (d <= bound) return d;
    end
    return w & (m >> 1);
  endfunction

  function automatic int lookup(logic [63:0] hi, logic [63:0] lo, logic [7:0] nif);
    for (int i = 0; i < mlgt_pkg::ENTRIES; i++)
      if (groups[i].used && groups[i].nif == nif && groups[i].hi == hi && groups[i].lo == lo)
        return i;
    return -1;
  endfunction

  // restart a timer unless a running one already answers in time
  function automatic bit rearm(int i, logic [31:0] now, logic [31:0] maxr, logic [31:0] d);
    logic [31:0] left;
    left = deadline_due(now, groups[i].dl) ? 32'd0 : groups[i].dl - now;
    if (groups[i].st == mlgt_pkg::LS_DELAY && maxr >= left) return 0;
    groups[i].dl = now + d;
    groups[i].st = mlgt_pkg::LS_DELAY;
    return 1;
  endfunction

  function automatic void report_entry(int i);
    held_result.index = IW'(i);
    held_result.ghigh = groups[i].hi;
    held_result.glow  = groups[i].lo;
    held_result.dl    = groups[i].dl;
    held_result.st    = groups[i].st;
    held_result.nif   = groups[i].nif;
    held_result.last  = groups[i].flag;
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < mlgt_pkg::ENTRIES; i++) groups[i] = '0;
  endfunction

  function automatic mlgt_pkg::res_t apply_op(op_word_t op);
    int i;
    int first;
    int cnt;
    logic [31:0] w;
    w = op.seed;
    case (op.func)
      mlgt_pkg::FN_JOIN: begin
        held_result.status = mlgt_pkg::RS_ERR; held_result.index = mlgt_pkg::IDX_NONE;
        held_result.report_now = 0;
        if (groups_ready && op.nif < mlgt_pkg::IF_COUNT && op.ghi[63:56] == 8'hFF) begin
          i = lookup(op.ghi, op.glo, op.nif);
          if (i >= 0) begin
            report_entry(i); held_result.status = mlgt_pkg::RS_OK;
          end else begin
            for (i = 0; i < mlgt_pkg::ENTRIES; i++) if (!groups[i].used) break;
            if (i >= mlgt_pkg::ENTRIES) begin
              held_result.status = mlgt_pkg::RS_BUSY;
            end else begin
              groups[i].used = 1; groups[i].hi = op.ghi; groups[i].lo = op.glo;
              groups[i].nif = op.nif;
              if (group_reports(op.ghi, op.glo)) begin
                groups[i].st = mlgt_pkg::LS_DELAY; groups[i].flag = 1;
                groups[i].dl = op.now + pull_delay(w, uri_bound);
                held_result.report_now = 1;
              end else begin
                groups[i].st = mlgt_pkg::LS_IDLE; groups[i].flag = 0; groups[i].dl = 0;
              end
              report_entry(i); held_result.status = mlgt_pkg::RS_OK;
            end
          end
        end
      end
      mlgt_pkg::FN_LEAVE: begin
        held_result.status = mlgt_pkg::RS_ERR; held_result.index = mlgt_pkg::IDX_NONE;
        held_result.done_now = 0;
        i = -1;
        if (groups_ready && op.nif < mlgt_pkg::IF_COUNT) i = lookup(op.ghi, op.glo, op.nif);
        if (i >= 0) begin
          held_result.done_now = done_for_all ? group_reports(op.ghi, op.glo) : groups[i].flag;
          held_result.last = groups[i].flag;
          groups[i] = '0;
          held_result.index = IW'(i);
          held_result.ghigh = op.ghi; held_result.glow = op.glo;
          held_result.dl = 0; held_result.st = mlgt_pkg::LS_NON; held_result.nif = op.nif;
          held_result.status = mlgt_pkg::RS_OK;
        end
      end
      mlgt_pkg::FN_FIND: begin
        held_result.status = mlgt_pkg::RS_ERR; held_result.index = mlgt_pkg::IDX_NONE;
        held_result.ghigh = 0; held_result.glow = 0; held_result.st = mlgt_pkg::LS_NON;
        held_result.dl = 0;
        i = groups_ready ? lookup(op.ghi, op.glo, op.nif) : -1;
        if (i >= 0) begin
          report_entry(i); held_result.status = mlgt_pkg::RS_OK;
        end
      end
      mlgt_pkg::FN_QUERY: begin
        held_result.status = mlgt_pkg::RS_ERR; held_result.index = mlgt_pkg::IDX_NONE;
        held_result.report_now = 0;
        if (groups_ready && op.nif < mlgt_pkg::IF_COUNT) begin
          if (!op.general) begin
            i = lookup(op.ghi, op.glo, op.nif);
            if (i >= 0) begin
              if (group_reports(groups[i].hi, groups[i].lo))
                void'(rearm(i, op.now, op.maxr, pull_delay(w, op.maxr)));
              report_entry(i); held_result.status = mlgt_pkg::RS_OK;
            end
          end else begin
            for (i = 0; i < mlgt_pkg::ENTRIES; i++) begin
              if (groups[i].used && groups[i].nif == op.nif &&
                  group_reports(groups[i].hi, groups[i].lo))
                if (rearm(i, op.now, op.maxr, pull_delay(w, op.maxr))) report_entry(i);
            end
            held_result.status = mlgt_pkg::RS_OK;
          end
        end
      end
      mlgt_pkg::FN_REPORT: begin
        held_result.status = mlgt_pkg::RS_ERR; held_result.index = mlgt_pkg::IDX_NONE;
        i = groups_ready ? lookup(op.ghi, op.glo, op.nif) : -1;
        if (i >= 0) begin
          if (groups[i].st == mlgt_pkg::LS_DELAY) begin
            groups[i].st = mlgt_pkg::LS_IDLE; groups[i].dl = 0; groups[i].flag = 0;
          end
          report_entry(i); held_result.status = mlgt_pkg::RS_OK;
        end
      end
      mlgt_pkg::FN_TICK: begin
        held_result.status = mlgt_pkg::RS_ERR; held_result.expired = 0;
        held_result.report_now = 0; held_result.index = mlgt_pkg::IDX_NONE;
        if (groups_ready) begin
          first = -1; cnt = 0;
          for (i = 0; i < mlgt_pkg::ENTRIES; i++)
            if (groups[i].used && groups[i].st == mlgt_pkg::LS_DELAY &&
                deadline_due(op.now, groups[i].dl)) begin
              cnt++;
              if (first < 0) first = i;
            end
          held_result.expired = IW'(cnt);
          if (first < 0) begin
            held_result.ghigh = 0; held_result.glow = 0;
          end else begin
            groups[first].st = mlgt_pkg::LS_IDLE; groups[first].flag = 1;
            groups[first].dl = 0;
            held_result.report_now = 1;
            report_entry(first);
          end
          held_result.status = mlgt_pkg::RS_OK;
        end
      end
      mlgt_pkg::FN_CLEAR: begin
        wipe_table(); groups_ready = 1; held_result.status = mlgt_pkg::RS_OK;
      end
      default: held_result.status = mlgt_pkg::RS_ERR;
    endcase
    return held_result;
  endfunction

  // ---------------- clock and stimulus helpers ----------------
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic op_word_t make_op(logic [2:0] f, int g, logic [7:0] nif);
    op_word_t op;
    op.func = f; op.ghi = pool_hi[g]; op.glo = pool_lo[g]; op.nif = nif;
    op.now = clock_ms; op.seed = $urandom; op.maxr = $urandom_range(0, 20000);
    op.general = 1'($urandom_range(0, 1));
    return op;
  endfunction

  function automatic op_word_t random_op();
    op_word_t op;
    int r;
    r = $urandom_range(0, 99);
    clock_ms = clock_ms + $urandom_range(0, 3000);
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
    op = make_op(mlgt_pkg::FN_JOIN, $urandom_range(0, POOL_SIZE - 1),
                 ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                 8'($urandom_range(0, mlgt_pkg::IF_COUNT - 1)));
    if (r < 30)      op.func = mlgt_pkg::FN_JOIN;
    else if (r < 42) op.func = mlgt_pkg::FN_LEAVE;
    else if (r < 54) op.func = mlgt_pkg::FN_FIND;
    else if (r < 68) op.func = mlgt_pkg::FN_QUERY;
    else if (r < 78) op.func = mlgt_pkg::FN_REPORT;
    else if (r < 95) op.func = mlgt_pkg::FN_TICK;
    else if (r < 96) op.func = mlgt_pkg::FN_CLEAR;
    else if (r < 98) op.func = mlgt_pkg::FN_UNDEF;
    else begin
      op.func = 3'($urandom); op.ghi = {$urandom, $urandom}; op.glo = {$urandom, $urandom};
      op.now = $urandom;
    end
    case ($urandom_range(0, 5))
      0: op.maxr = 32'd0;
      1: op.maxr = 32'hFFFF_FFFF;
      2: op.maxr = $urandom;
      default: ;
    endcase
    if ($urandom_range(0, 19) == 0) op.seed = 32'd0;
    return op;
  endfunction

  task automatic write_reg(logic [mlgt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg.valid <= 1; cfg.index <= idx; cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 0;
    if (idx == mlgt_pkg::CFG_URI) uri_bound = value;
    else done_for_all = value[0];
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || expected_results.size() != 0 || req.valid)
      @(posedge clk);
  endtask

  // ---------------- request driver ----------------
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 0;
    end else begin
      if (req.valid && req.ready) begin
        expected_results.push_back(apply_op(pending_ops[0]));
        void'(pending_ops.pop_front());
      end
      if (!(req.valid && !req.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          req.valid <= 0;
        end else if (pending_ops.size() > 0) begin
          req.valid <= 1;
          req.func <= pending_ops[0].func; req.group_high <= pending_ops[0].ghi;
          req.group_low <= pending_ops[0].glo; req.netif <= pending_ops[0].nif;
          req.now_ms <= pending_ops[0].now; req.random_word <= pending_ops[0].seed;
          req.resp_limit_ms <= pending_ops[0].maxr;
          req.general_query <= pending_ops[0].general;
          if (idling_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 14);
        end else begin
          req.valid <= 0;
        end
      end
    end
  end

  // ---------------- response ready and checker ----------------
  always @(posedge clk) begin
    mlgt_pkg::res_t got;
    mlgt_pkg::res_t want;
    if (rst) begin
      rsp.ready <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = {rsp.status, rsp.entry_index, rsp.out_group_high, rsp.out_group_low,
               rsp.out_deadline_ms, rsp.out_state, rsp.out_netif, rsp.out_last_reporter,
               rsp.report_now, rsp.done_now, rsp.expired_count};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.index !== want.index ||
              got.ghigh !== want.ghigh || got.glow !== want.glow || got.dl !== want.dl ||
              got.st !== want.st || got.nif !== want.nif || got.last !== want.last ||
              got.report_now !== want.report_now || got.done_now !== want.done_now ||
              got.expired !== want.expired) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      // receiver: long hold-off on request, else random stall bursts
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 0;
      end else if (hold_request) begin
        hold_request = 0;
        hold_left = HOLD_CYCLES;
        rsp.ready <= 0;
      end else if (rsp_stall > 0) begin
        rsp_stall--;
        rsp.ready <= 0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        rsp_stall = $urandom_range(1, 14);
        rsp.ready <= 0;
      end else begin
        rsp.ready <= 1;
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // ---------------- main sequence ----------------
  initial begin
    logic [31:0] uri_set [5];
    logic        done_set [5];
    req.valid = 0; req.func = 0; req.group_high = 0; req.group_low = 0; req.netif = 0;
    req.now_ms = 0; req.random_word = 0; req.resp_limit_ms = 0; req.general_query = 0;
    cfg.valid = 0; cfg.index = 0; cfg.data = 0;
    rsp.ready = 0;
    fail_count = 0; send_gap = 0; rsp_stall = 0; hold_left = 0; idle_cycles = 0;
    idling_on = 1; hold_request = 0;
    clock_ms = 32'hFFFF_F000;
    uri_bound = mlgt_pkg::URI_RESET; done_for_all = 0; groups_ready = 0; held_result = '0;
    wipe_table();

    // group pool: all-nodes, interface scope, reportable, unicast and random multicast
    pool_hi[0] = 64'hFF02_0000_0000_0000; pool_lo[0] = 64'd1;
    pool_hi[1] = 64'hFF01_0000_0000_0000; pool_lo[1] = 64'd2;
    pool_hi[2] = 64'hFF02_0000_0000_0000; pool_lo[2] = 64'd2;
    pool_hi[3] = 64'h2001_0DB8_0000_0000; pool_lo[3] = 64'd1;
    pool_hi[4] = 64'hFFFF_FFFF_FFFF_FFFF; pool_lo[4] = 64'hFFFF_FFFF_FFFF_FFFF;
    pool_hi[5] = 64'hFF00_0000_0000_0000; pool_lo[5] = 64'd0;
    for (int i = 6; i < POOL_SIZE; i++) begin
      pool_hi[i] = {8'hFF, 8'($urandom), 16'($urandom), $urandom};
      pool_lo[i] = {$urandom, $urandom};
    end

    rst = 1;
    repeat (5) @(posedge clk);
    rst <= 0;

    // directed: operations before clear, then each operation and corner once
    pending_ops.push_back(make_op(mlgt_pkg::FN_JOIN, 2, 0));
    pending_ops.push_back(make_op(mlgt_pkg::FN_LEAVE, 2, 0));
    pending_ops.push_back(make_op(mlgt_pkg::FN_FIND, 2, 0));
    pending_ops.push_back(make_op(mlgt_pkg::FN_QUERY, 2, 0));
    pending_ops.push_back(make_op(mlgt_pkg::FN_REPORT, 2, 0));
    pending_ops.push_back(make_op(mlgt_pkg::FN_TICK, 2, 0));
    pending_ops.push_back(make_op(mlgt_pkg::FN_UNDEF, 2, 0));
    pending_ops.push_back(make_op(mlgt_pkg::FN_CLEAR, 0, 0));
    pending_ops.push_back(make_op(mlgt_pkg::FN_JOIN, 0, 0));
    pending_ops.push_back(make_op(mlgt_pkg::FN_JOIN, 1, 1));
    pending_ops.push_back(make_op(mlgt_pkg::FN_JOIN, 3, 0));
    pending_ops.push_back(make_op(mlgt_pkg::FN_JOIN, 2, 8'd4));
    pending_ops.push_back(make_op(mlgt_pkg::FN_JOIN, 2, 8'd255));
    pending_ops.push_back(make_op(mlgt_pkg::FN_JOIN, 2, 0));
    pending_ops.push_back(make_op(mlgt_pkg::FN_JOIN, 4, 3));
    pending_ops.push_back(make_op(mlgt_pkg::FN_JOIN, 2, 0));
    pending_ops.push_back(make_op(mlgt_pkg::FN_FIND, 2, 0));
    pending_ops.push_back(make_op(mlgt_pkg::FN_FIND, 5, 0));
    pending_ops[$].general = 0;
    pending_ops.push_back(make_op(mlgt_pkg::FN_QUERY, 2, 0));
    pending_ops[$].general = 0; pending_ops[$].maxr = 32'd0;
    pending_ops.push_back(make_op(mlgt_pkg::FN_QUERY, 4, 3));
    pending_ops[$].general = 1; pending_ops[$].maxr = 32'hFFFF_FFFF;
    pending_ops.push_back(make_op(mlgt_pkg::FN_REPORT, 2, 0));
    pending_ops.push_back(make_op(mlgt_pkg::FN_TICK, 0, 0));
    pending_ops[$].now = clock_ms + 32'h0010_0000;
    pending_ops.push_back(make_op(mlgt_pkg::FN_LEAVE, 4, 3));
    pending_ops.push_back(make_op(mlgt_pkg::FN_LEAVE, 5, 0));
    pending_ops.push_back(make_op(mlgt_pkg::FN_LEAVE, 0, 0));
    wait_drained();

    uri_set[0] = mlgt_pkg::URI_RESET; done_set[0] = 0;
    uri_set[1] = 32'd0;        done_set[1] = 1;
    uri_set[2] = 32'hFFFF_FFFF; done_set[2] = 0;
    uri_set[3] = 32'd50;       done_set[3] = 1;
    uri_set[4] = $urandom;     done_set[4] = 0;

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(mlgt_pkg::CFG_URI, uri_set[ph]);
      write_reg(mlgt_pkg::CFG_DONE, 32'(done_set[ph]));
      if (ph == 4) idling_on = 0;
      pending_ops.push_back(make_op(mlgt_pkg::FN_CLEAR, 0, 0));
      for (int n = 0; n < 390; n++) begin
        pending_ops.push_back(random_op());
        if (ph == 1 && n == 150) hold_request = 1;
        if (ph == 2 && n == 200) wait_drained();
        while (pending_ops.size() > 8) @(posedge clk);
      end
      wait_drained();
    end

    repeat (250) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
